// ===== rtl/lrf_pkg.sv =====
// Shared types and constants for the line raster frame buffer block.
// Used by line_raster_to_framebuffer_top; no dependencies.
package lrf_pkg;

    // Frame store geometry and pixel depth
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int PIXEL_BITS  = 8;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Register and field widths
    localparam int SIZE_W  = 7;     // image_width / image_height
    localparam int LEVEL_W = 8;     // white_level, pixel_value, read_value
    localparam int CRD_W   = 8;     // signed end point coordinates
    localparam int PIX_W   = 6;     // pixel_x / pixel_y
    localparam int CFG_W   = 8;     // widest register
    localparam int CFG_IDX_W = 2;

    // Working widths of the line walker
    localparam int STEP_W = CRD_W + 2;      // half-pixel position, deltas
    localparam int MIN_W  = CRD_W + 3;      // minor coordinate
    localparam int IDX_W  = 2 * SIZE_W;     // linear pixel index before range check

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    // Result kinds
    localparam logic RK_READ = 1'b0;
    localparam logic RK_DONE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE  = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0]  WIDTH_RST  = 7'd64;
    localparam logic [SIZE_W-1:0]  HEIGHT_RST = 7'd64;
    localparam logic [LEVEL_W-1:0] WHITE_RST  = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAW,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [CRD_W-1:0] start_x;
        logic signed [CRD_W-1:0] start_y;
        logic signed [CRD_W-1:0] end_x;
        logic signed [CRD_W-1:0] end_y;
        logic                    white_line;
        logic [PIX_W-1:0]        pixel_x;
        logic [PIX_W-1:0]        pixel_y;
        logic [LEVEL_W-1:0]      pixel_value;
    } cmd_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [LEVEL_W-1:0] read_value;
    } rsp_word_t;

endpackage

// ===== rtl/lrf_ram.sv =====
// Simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds until the next read; no dependencies.
module lrf_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/line_raster_to_framebuffer_top.sv =====
// Grayscale frame buffer with a line rasterizer. A command word writes a pixel
// (no result), reads a pixel (the store read is registered, and the result is loaded
// once the output register is free, together with the return to idle) or draws a line
// (half-pixel steps from lo to hi, the major-axis end points, then one done result). The
// line walker makes one half-pixel step per cycle and writes at most one pixel per step
// through the single write port of the frame store; the minor coordinate is kept as an
// exact quotient and remainder, so no divider is needed. One command is in flight at a
// time. Pixels never written read back as undefined. Configuration writes are taken any
// cycle but belong in idle time.
// Depends on lrf_pkg and lrf_ram.
module line_raster_to_framebuffer_top
    import lrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_word_t            cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_word_t            rsp
);

    // Configuration registers
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [LEVEL_W-1:0] white_reg;

    // Control
    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    rsp_word_t rsp_reg, rsp_next;
    logic   read_oob_reg;

    // Line walker registers
    logic                     xmaj_reg;
    logic signed [STEP_W-1:0] m2_reg;
    logic signed [STEP_W-1:0] end_reg;
    logic signed [STEP_W-1:0] q_reg;
    logic        [STEP_W-1:0] rem_reg;
    logic        [STEP_W-1:0] den_reg;
    logic signed [STEP_W-1:0] inc_reg;
    logic signed [CRD_W-1:0]  base_reg;
    logic [PIXEL_BITS-1:0]    color_reg;

    // Frame store ports
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [PIXEL_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [PIXEL_BITS-1:0] ram_rdata;

    logic cmd_fire;
    logic rsp_free;
    logic [SIZE_W-1:0] eff_w;
    logic [SIZE_W-1:0] eff_h;

    // Saturate active size to the store geometry
    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : height_reg;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            white_reg  <= WHITE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                CFG_WHITE:  white_reg  <= cfg_data[LEVEL_W-1:0];
                default:    ;
            endcase
        end
    end

    // Pixel address for single-pixel access
    logic [IDX_W-1:0] pix_idx;
    logic             pix_in_store;

    assign pix_idx = IDX_W'(cmd.pixel_y) * IDX_W'(eff_w) + IDX_W'(cmd.pixel_x);
    assign pix_in_store = (32'(pix_idx) < STORE_DEPTH);

    // Line setup: pick the major axis and seed quotient and remainder
    logic signed [STEP_W-1:0] sx, sy, ex, ey, dx, dy, adx, ady;
    logic signed [STEP_W-1:0] a0, a1, dmaj, dmin, lo, hi;
    logic signed [STEP_W-1:0] setup_q, setup_inc;
    logic        [STEP_W-1:0] setup_den;
    logic signed [CRD_W-1:0]  setup_base;
    logic                     setup_xmaj;

    always_comb
    begin
        sx  = STEP_W'(cmd.start_x);
        sy  = STEP_W'(cmd.start_y);
        ex  = STEP_W'(cmd.end_x);
        ey  = STEP_W'(cmd.end_y);
        dx  = ex - sx;
        dy  = ey - sy;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        setup_xmaj = (ady < adx) || (dy == '0);
        if (setup_xmaj)
        begin
            a0 = sx;
            a1 = ex;
            dmaj = dx;
            dmin = dy;
            setup_base = cmd.start_y;
        end
        else
        begin
            a0 = sy;
            a1 = ey;
            dmaj = dy;
            dmin = dx;
            setup_base = cmd.start_x;
        end
        lo = (a0 < a1) ? a0 : a1;
        hi = (a0 < a1) ? a1 : a0;
        // Walk starts at the lower end point; from the far end the quotient is dmin exactly
        setup_q   = (a0 <= a1) ? '0 : dmin;
        setup_inc = (dmaj < 0) ? -dmin : dmin;
        setup_den = STEP_W'((dmaj < 0) ? -dmaj : dmaj) << 1;
    end

    // Current step: plot point, clip and next remainder
    logic signed [MIN_W-1:0]  major_c, minor_c, px_c, py_c;
    logic signed [MIN_W-1:0]  w_s, h_s;
    logic signed [STEP_W:0]   rem_sum;
    logic                     step_active, in_clip;
    logic [IDX_W-1:0]         plot_idx;
    logic                     plot_in_store;

    always_comb
    begin
        step_active = (m2_reg < end_reg);
        major_c = MIN_W'(m2_reg >>> 1);
        minor_c = MIN_W'(q_reg) + MIN_W'(base_reg);
        px_c = xmaj_reg ? major_c : minor_c;
        py_c = xmaj_reg ? minor_c : major_c;
        w_s = MIN_W'(eff_w);
        h_s = MIN_W'(eff_h);
        in_clip = (m2_reg >= 0) && (px_c >= 0) && (py_c >= 0) && (px_c < w_s) && (py_c < h_s);
        plot_idx = IDX_W'(py_c[SIZE_W-1:0]) * IDX_W'(eff_w) + IDX_W'(px_c[SIZE_W-1:0]);
        plot_in_store = (32'(plot_idx) < STORE_DEPTH);
        rem_sum = $signed({1'b0, rem_reg}) + (STEP_W+1)'(inc_reg);
    end

    // Next state, frame store access and result load
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we    = 1'b0;
        ram_waddr = pix_idx[ADDR_W-1:0];
        ram_wdata = PIXEL_BITS'(cmd.pixel_value);
        ram_re    = 1'b0;
        ram_raddr = pix_idx[ADDR_W-1:0];

        // Drop the output word once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.operation)
                        OP_WRITE: ram_we = pix_in_store;
                        OP_READ:
                        begin
                            ram_re = 1'b1;
                            state_next = ST_READ;
                        end
                        OP_DRAW:  state_next = ST_DRAW;
                        default:  ;
                    endcase
                end
            end
            ST_READ:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.result_kind = RK_READ;
                    rsp_next.read_value  = read_oob_reg ? '0 : LEVEL_W'(ram_rdata);
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW:
            begin
                ram_waddr = plot_idx[ADDR_W-1:0];
                ram_wdata = color_reg;
                if (step_active)
                begin
                    ram_we = in_clip && plot_in_store;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.result_kind = RK_DONE;
                    rsp_next.read_value  = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Load the walker on every accepted command, advance it one half pixel per cycle while drawing
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            read_oob_reg <= !pix_in_store;
            xmaj_reg  <= setup_xmaj;
            m2_reg    <= lo <<< 1;
            end_reg   <= hi <<< 1;
            q_reg     <= setup_q;
            rem_reg   <= '0;
            den_reg   <= setup_den;
            inc_reg   <= setup_inc;
            base_reg  <= setup_base;
            color_reg <= cmd.white_line ? PIXEL_BITS'(white_reg) : '0;
        end
        else if (state_reg == ST_DRAW && step_active)
        begin
            m2_reg <= m2_reg + STEP_W'(1);
            if (rem_sum >= $signed({1'b0, den_reg}))
            begin
                rem_reg <= STEP_W'(rem_sum - $signed({1'b0, den_reg}));
                q_reg   <= q_reg + STEP_W'(1);
            end
            else if (rem_sum < 0)
            begin
                rem_reg <= STEP_W'(rem_sum + $signed({1'b0, den_reg}));
                q_reg   <= q_reg - STEP_W'(1);
            end
            else
            begin
                rem_reg <= STEP_W'(rem_sum);
            end
        end
    end

    lrf_ram #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (PIXEL_BITS),
        .ADDR_W (ADDR_W)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef ASSERT_OFF
    // Remainder stays below the denominator while stepping
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && step_active) |-> (rem_reg < den_reg))
        else $error("line walker remainder out of range");

    // Frame store is written only on a pixel write or a draw step
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE || state_reg == ST_DRAW))
        else $error("frame store write outside write or draw");

    // A new output word comes only from a read or a finished draw
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_READ || $past(state_reg) == ST_FINISH))
        else $error("output word loaded from wrong state");

    // An accepted read always goes to the read-data state
    a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && cmd.operation == OP_READ) |=> (state_reg == ST_READ))
        else $error("read command did not reach read state");
`endif

endmodule
